// ===== src/bpe_pkg.sv =====
package bpe_pkg;

   localparam int COORD_W  = 16;
   localparam int PARAM_W  = 17;
   localparam int INDEX_W  = 3;
   localparam int PCOUNT_W = 4;

   // Q0.16 one, and the rounding half-step of a lerp
   localparam logic [PARAM_W-1:0] PARAM_ONE = 17'h10000;
   localparam logic signed [2*PARAM_W:0] ROUND_HALF = 35'sd32768;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_EVAL  = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } point_type;

endpackage

// ===== src/bpe_if.sv =====
interface bpe_req_if import bpe_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [INDEX_W-1:0]        point_index;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic [PARAM_W-1:0]        param_t;

   modport source (output valid, mode, point_index, point_x, point_y, param_t, input ready);
   modport sink   (input valid, mode, point_index, point_x, point_y, param_t, output ready);
endinterface

interface bpe_rsp_if import bpe_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] curve_x;
   logic signed [COORD_W-1:0] curve_y;

   modport source (output valid, curve_x, curve_y, input ready);
   modport sink   (input valid, curve_x, curve_y, output ready);
endinterface

interface bpe_csr_if import bpe_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PCOUNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== src/bezier_point_evaluator.sv =====
// Bezier point evaluator (de Casteljau). A request word with mode 0 stores one
// signed Q8.8 control point in slot point_index and gives no response; a word
// with mode 1 gives one response word, the curve over the first point_count
// stored points at param_t (Q0.16, values above one are taken as one). A count
// of 0 gives (0,0), a count above MAX_CONTROL_POINTS is taken as the maximum,
// and a write to a slot at or above MAX_CONTROL_POINTS is dropped. One request
// word is taken every cycle while the response side keeps up: the triangle is
// a pipeline of one snapshot stage, MAX_CONTROL_POINTS-1 interpolation stages
// (one de Casteljau level each, one multiplier per lane and axis) and an
// output register. An evaluation sees every point written before it. Stalls on
// the response side fill the pipeline's empty stages before they hold the
// request side. point_count is written through the csr channel, which is
// always ready and must be used only while no evaluation is in flight.
module bezier_point_evaluator
   import bpe_pkg::*;
#(
   parameter int MAX_CONTROL_POINTS = 8
) (
   input  logic   clock,
   input  logic   reset,
   bpe_req_if.sink   req_bus,
   bpe_rsp_if.source rsp_bus,
   bpe_csr_if.sink   csr_bus
);

   localparam int NPTS   = MAX_CONTROL_POINTS;
   localparam int LAST   = NPTS - 1;            // index of the last level stage
   localparam int LVL_W  = $clog2(NPTS);

   // one interpolation: a + round((b - a) * t / 2^16), floor shift
   function automatic logic signed [COORD_W-1:0] lerp(
      input logic signed [COORD_W-1:0] a,
      input logic signed [COORD_W-1:0] b,
      input logic [PARAM_W-1:0]        t
   );
      logic signed [COORD_W:0]    diff;
      logic signed [PARAM_W:0]    ts;
      logic signed [2*PARAM_W:0]  prod;
      logic signed [COORD_W:0]    sum;
      diff = {b[COORD_W-1], b} - {a[COORD_W-1], a};
      ts   = {1'b0, t};
      prod = diff * ts + ROUND_HALF;
      sum  = {a[COORD_W-1], a} + prod[COORD_W+16:16];
      return sum[COORD_W-1:0];
   endfunction

   // control point bank and count register
   point_type           pts_ff [NPTS];
   logic [PCOUNT_W-1:0] count_ff;

   // pipeline: stage 0 holds the snapshot, stage s has done s levels
   logic               vld_ff  [NPTS];
   logic               rdy     [NPTS];
   point_type          pipe_ff [NPTS][NPTS];
   point_type          pipe_in [NPTS][NPTS];
   point_type          snap_in [NPTS];
   logic [PARAM_W-1:0] t_ff    [NPTS];
   logic [LVL_W-1:0]   lvl_ff  [NPTS];
   logic [PARAM_W-1:0] t_in;
   logic [LVL_W-1:0]   lvl_in;

   logic      out_vld_ff;
   point_type out_ff;
   logic      out_rdy;

   logic accept;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = rdy[0];
   assign accept        = req_bus.valid && rdy[0];

   // hold each stage until the one after it can take its word
   assign out_rdy = !out_vld_ff || rsp_bus.ready;
   always_comb begin
      rdy[LAST] = !vld_ff[LAST] || out_rdy;
      for (int s = LAST - 1; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s + 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < NPTS; i++) begin
            pts_ff[i] <= '0;
         end
      end else begin
         if (csr_bus.valid) begin
            count_ff <= csr_bus.data;
         end
         if (accept && req_bus.mode == MODE_WRITE) begin
            for (int i = 0; i < NPTS; i++) begin
               if (int'(req_bus.point_index) == i) begin
                  pts_ff[i] <= '{y: req_bus.point_y, x: req_bus.point_x};
               end
            end
         end
      end
   end

   // snapshot stage: clamp t and count, turn the count into a number of levels
   always_comb begin
      int n_v;
      n_v    = (int'(count_ff) > NPTS) ? NPTS : int'(count_ff);
      lvl_in = (n_v == 0) ? '0 : LVL_W'(n_v - 1);
      t_in   = (req_bus.param_t > PARAM_ONE) ? PARAM_ONE : req_bus.param_t;
      for (int i = 0; i < NPTS; i++) begin
         snap_in[i] = (n_v == 0) ? '0 : pts_ff[i];
      end
   end

   // level stages: stage s interpolates only when the curve has s levels or more,
   // otherwise pass the row through
   always_comb begin
      int j;
      pipe_in[0] = snap_in;
      for (int s = 1; s < NPTS; s++) begin
         for (int i = 0; i < NPTS; i++) begin
            j = (i < LAST) ? i + 1 : i;
            if (i < LAST && int'(lvl_ff[s - 1]) >= s) begin
               pipe_in[s][i].x = lerp(pipe_ff[s - 1][i].x, pipe_ff[s - 1][j].x,
                                      t_ff[s - 1]);
               pipe_in[s][i].y = lerp(pipe_ff[s - 1][i].y, pipe_ff[s - 1][j].y,
                                      t_ff[s - 1]);
            end else begin
               pipe_in[s][i] = pipe_ff[s - 1][i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NPTS; s++) begin
            vld_ff[s] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_bus.valid && req_bus.mode == MODE_EVAL;
         end
         for (int s = 1; s < NPTS; s++) begin
            if (rdy[s]) begin
               vld_ff[s] <= vld_ff[s - 1];
            end
         end
         if (out_rdy) begin
            out_vld_ff <= vld_ff[LAST];
         end
      end
   end

   // payload: advance with the valid bits, no reset
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         pipe_ff[0] <= pipe_in[0];
         t_ff[0]    <= t_in;
         lvl_ff[0]  <= lvl_in;
      end
      for (int s = 1; s < NPTS; s++) begin
         if (rdy[s]) begin
            pipe_ff[s] <= pipe_in[s];
            t_ff[s]    <= t_ff[s - 1];
            lvl_ff[s]  <= lvl_ff[s - 1];
         end
      end
      if (out_rdy) begin
         out_ff <= pipe_ff[LAST][0];
      end
   end

   assign rsp_bus.valid   = out_vld_ff;
   assign rsp_bus.curve_x = out_ff.x;
   assign rsp_bus.curve_y = out_ff.y;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import bpe_pkg::*;

   localparam int MAX_PTS      = 8;
   // time for a word to leave the pipeline: snapshot, levels, output register, margin
   localparam int DRAIN_CYCLES = MAX_PTS + 6;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam logic [COORD_W-1:0] COORD_BIAS = 16'h8000;
   localparam logic [63:0]        ROUND_Q16  = 64'd32768;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpe_req_if req_bus ();
   bpe_rsp_if rsp_bus ();
   bpe_csr_if csr_bus ();

   bezier_point_evaluator #(
      .MAX_CONTROL_POINTS(MAX_PTS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always #10 clock = ~clock;

   // Shadow of the block: control point bank, point_count and expected curve points
   point_type          ctrl_points [MAX_PTS];
   logic [PCOUNT_W-1:0] active_count;
   point_type          expected_points [$];

   int error_count    = 0;
   int writes_seen    = 0;
   int evals_checked  = 0;
   int settings_made  = 0;
   int cycle_count    = 0;

   // Idling knobs, in percent per request word or per receiver cycle; hold_request asks the receiver for a long stall
   int req_gap_pct    = 0;
   int rsp_gap_pct    = 0;
   int hold_request   = 0;

   // Blend two biased coordinates: (a*(1-t) + b*t + half) >> 16
   function automatic logic [COORD_W-1:0] blend_biased(logic [COORD_W-1:0] a,
                                                       logic [COORD_W-1:0] b,
                                                       logic [PARAM_W-1:0] t);
      logic [63:0] acc;
      acc = 64'(a) * 64'(PARAM_ONE - t) + 64'(b) * 64'(t) + ROUND_Q16;
      return acc[31:16];
   endfunction

   // Run the de Casteljau triangle over the first active_count points
   function automatic point_type evaluate_curve(logic [PARAM_W-1:0] t_in);
      logic [COORD_W-1:0] xs [MAX_PTS];
      logic [COORD_W-1:0] ys [MAX_PTS];
      logic [PARAM_W-1:0] t;
      int                 n;
      point_type          res;
      t = (t_in > PARAM_ONE) ? PARAM_ONE : t_in;
      n = (active_count > MAX_PTS) ? MAX_PTS : int'(active_count);
      // no points at all gives the origin
      if (n == 0) return '0;
      for (int i = 0; i < n; i++) begin
         xs[i] = ctrl_points[i].x ^ COORD_BIAS;
         ys[i] = ctrl_points[i].y ^ COORD_BIAS;
      end
      for (int lvl = n - 1; lvl > 0; lvl--) begin
         for (int i = 0; i < lvl; i++) begin
            xs[i] = blend_biased(xs[i], xs[i+1], t);
            ys[i] = blend_biased(ys[i], ys[i+1], t);
         end
      end
      res.x = xs[0] ^ COORD_BIAS;
      res.y = ys[0] ^ COORD_BIAS;
      return res;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(9) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   // Sample all three channels at the rising edge: record requests and register
   // writes into the shadow first, then check whatever response word arrived.
   always @(posedge clock) begin
      point_type got;
      point_type want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            active_count = csr_bus.data;
            settings_made++;
         end
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.mode == MODE_EVAL) begin
               expected_points.push_back(evaluate_curve(req_bus.param_t));
            end else begin
               // drop writes past the end of the bank
               if (req_bus.point_index < MAX_PTS)
                  ctrl_points[req_bus.point_index] = '{y: req_bus.point_y, x: req_bus.point_x};
               writes_seen++;
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.x = rsp_bus.curve_x;
            got.y = rsp_bus.curve_y;
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected response word x=%0d y=%0d", $time, got.x, got.y);
               error_count++;
            end else begin
               want = expected_points.pop_front();
               if (got.x !== want.x) begin
                  $display("%0t: curve_x mismatch, expected %0d, got %0d",
                           $time, want.x, got.x);
                  error_count++;
               end
               if (got.y !== want.y) begin
                  $display("%0t: curve_y mismatch, expected %0d, got %0d",
                           $time, want.y, got.y);
                  error_count++;
               end
               evals_checked++;
            end
         end
      end
   end

   // Receiver: honour a requested hold-off first, then random stalls
   always @(negedge clock) begin
      int stall_left;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_request > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_request--;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(99) < rsp_gap_pct) begin
         rsp_bus.ready <= 1'b0;
         stall_left = pick_gap() - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                  $time, cycle_count, expected_points.size());
         $display("simulation failed");
         $finish;
      end
   end

   // Offer one request word, hold it until accepted, then maybe leave a gap
   task automatic send_word(input logic mode, input logic [INDEX_W-1:0] idx,
                            input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py,
                            input logic [PARAM_W-1:0] t);
      int gap;
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.mode        <= mode;
      req_bus.point_index <= idx;
      req_bus.point_x     <= px;
      req_bus.point_y     <= py;
      req_bus.param_t     <= t;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      gap = ($urandom_range(99) < req_gap_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stop offering, wait for every response, then let stray writes flush out
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Change point_count, only with the pipeline empty
   task automatic write_point_count(input logic [PCOUNT_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(15))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0000;
         3:       return 16'shFFFF;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic logic [PARAM_W-1:0] rand_param();
      int r;
      r = $urandom_range(99);
      if (r < 8)  return '0;
      if (r < 16) return PARAM_ONE;
      if (r < 24) return PARAM_W'($urandom_range(65537, 131071));
      return PARAM_W'($urandom_range(0, 65536));
   endfunction

   // Fresh after reset: an empty count gives the origin, one point gives the
   // untouched (zero) slot 0
   task automatic test_reset_state();
      req_gap_pct = 30;
      rsp_gap_pct = 30;
      send_word(MODE_EVAL, 3'($urandom), rand_coord(), rand_coord(), 17'h0C000);
      write_point_count(4'd1);
      send_word(MODE_EVAL, 3'($urandom), rand_coord(), rand_coord(), PARAM_ONE);
      wait_drained();
   endtask

   // Fill the bank with extreme coordinates and evaluate at the edges of t, above
   // one and in between, then walk point_count over its special values
   task automatic test_corner_points();
      logic signed [COORD_W-1:0] corner_x [MAX_PTS] = '{16'sh8000, 16'sh7FFF, 16'sh8000,
         16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh7FFF};
      logic signed [COORD_W-1:0] corner_y [MAX_PTS] = '{16'sh7FFF, 16'sh8000, 16'shFFFF,
         16'sh0000, 16'sh7FFF, 16'sh8000, 16'sh0100, 16'sh8000};
      for (int i = 0; i < MAX_PTS; i++)
         send_word(MODE_WRITE, 3'(i), corner_x[i], corner_y[i], PARAM_W'($urandom));
      write_point_count(4'd8);
      send_word(MODE_EVAL, 3'd7, 16'sh7FFF, 16'sh8000, 17'h00000);
      send_word(MODE_EVAL, 3'd0, 16'sh8000, 16'sh7FFF, PARAM_ONE);
      send_word(MODE_EVAL, 3'd5, rand_coord(), rand_coord(), 17'h10001);  // above one
      send_word(MODE_EVAL, 3'd2, rand_coord(), rand_coord(), 17'h1FFFF);
      send_word(MODE_EVAL, 3'd3, rand_coord(), rand_coord(), 17'h08000);
      send_word(MODE_EVAL, 3'd1, rand_coord(), rand_coord(), 17'h00001);
      write_point_count(4'd15);   // clamps to a full bank
      send_word(MODE_EVAL, 3'($urandom), rand_coord(), rand_coord(), 17'h04000);
      write_point_count(4'd1);    // first point only
      send_word(MODE_EVAL, 3'($urandom), rand_coord(), rand_coord(), 17'h0ABCD);
      write_point_count(4'd0);    // origin
      send_word(MODE_EVAL, 3'($urandom), rand_coord(), rand_coord(), 17'h0ABCD);
      write_point_count(4'd2);    // plain line
      send_word(MODE_EVAL, 3'($urandom), rand_coord(), rand_coord(), 17'h08000);
      wait_drained();
   endtask

   // Phases of mixed writes and evaluations, each under its own point_count;
   // every fourth phase runs with no idling on either side
   task automatic test_random_traffic();
      logic [PCOUNT_W-1:0] opening [5] = '{4'd0, 4'd1, 4'd8, 4'd15, 4'd2};
      logic [PCOUNT_W-1:0] count;
      for (int phase = 0; phase < 16; phase++) begin
         count = (phase < 5) ? opening[phase] : PCOUNT_W'($urandom);
         write_point_count(count);
         req_gap_pct = (phase % 4 == 0) ? 0 : $urandom_range(10, 40);
         rsp_gap_pct = (phase % 4 == 0) ? 0 : $urandom_range(10, 40);
         for (int k = 0; k < 100; k++) begin
            if ($urandom_range(99) < 35)
               send_word(MODE_WRITE, 3'($urandom), rand_coord(), rand_coord(),
                         PARAM_W'($urandom));
            else
               send_word(MODE_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_param());
         end
      end
      wait_drained();
   endtask

   // Hold the receiver off while evaluations keep coming back to back, so the
   // pipeline fills and the request side has to stall
   task automatic test_backpressure();
      write_point_count(4'd8);
      req_gap_pct  = 0;
      rsp_gap_pct  = 0;
      hold_request = 80;
      for (int k = 0; k < 40; k++)
         send_word(MODE_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_param());
      rsp_gap_pct = 25;
      for (int k = 0; k < 30; k++)
         send_word(MODE_EVAL, 3'($urandom), rand_coord(), rand_coord(), rand_param());
      wait_drained();
   endtask

   initial begin
      // the shadow starts as the block does after reset
      foreach (ctrl_points[i]) ctrl_points[i] = '0;
      active_count                   = '0;
      req_bus.valid                  = 1'b0;
      req_bus.mode                   = MODE_WRITE;
      req_bus.point_index            = '0;
      req_bus.point_x                = '0;
      req_bus.point_y                = '0;
      req_bus.param_t                = '0;
      csr_bus.valid                  = 1'b0;
      csr_bus.data                   = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_corner_points();
      test_backpressure();
      test_random_traffic();

      $display("Checked %0d curve points against %0d control point writes,",
               evals_checked, writes_seen);
      $display("across %0d point_count settings, a long receiver hold-off and random gaps.",
               settings_made);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/bpe_pkg.sv
src/bpe_if.sv
src/bezier_point_evaluator.sv
tb/testbench.sv
